FILE: rtl/mclod_pkg.sv
// shared types and constants for the multi-camera level-of-detail classifier
package mclod_pkg;

   localparam int CameraSlots = 4;
   localparam int SlotWidth = $clog2(CameraSlots);
   localparam int ElemsPerCamera = 12;
   localparam int StoreDepth = CameraSlots * ElemsPerCamera;
   localparam int StoreAddrWidth = $clog2(StoreDepth);

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [2:0] CSR_BEHIND = 3'd0;
   localparam logic [2:0] CSR_FOCUS = 3'd1;
   localparam logic [2:0] CSR_HIGH = 3'd2;
   localparam logic [2:0] CSR_MEDIUM = 3'd3;
   localparam logic [2:0] CSR_LOW = 3'd4;

   localparam logic [2:0] LEVEL_PERIPHERY = 3'd4;
   localparam logic [2:0] LEVEL_ABSENT = 3'd5;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] camera_slot;
      logic [3:0] element_index;
      logic [31:0] element_value;
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] point_z;
   } req_type_type;

   // result of one camera: level and squared distance
   typedef struct packed {
      logic valid;
      logic [2:0] level;
      logic [63:0] dist_sq;
   } cam_result_type;

endpackage

FILE: rtl/mclod_camera_unit.sv
// per-camera transform and classification, fed one matrix element per cycle
module mclod_camera_unit (
   input logic clock,
   input logic reset,
   input logic elem_valid,               // rd_data holds an element
   input logic [3:0] elem_index,
   input logic [31:0] rd_data,
   input logic [31:0] point_x,
   input logic [31:0] point_y,
   input logic [31:0] point_z,
   input logic [31:0] behind_limit,
   input logic [63:0] focus_sq,
   input logic [63:0] high_sq,
   input logic [63:0] medium_sq,
   input logic [63:0] low_sq,
   output mclod_pkg::cam_result_type result
);
   import mclod_pkg::*;

   logic signed [48:0] acc_ff [3];
   logic signed [48:0] acc_in [3];
   logic signed [63:0] prod_ff, prod_in;
   logic [1:0] prod_row_ff;
   logic prod_vld_ff, prod_first_ff;
   logic done1_ff, done2_ff;
   logic [1:0] sq_row_ff;
   logic [63:0] sq_ff [3];
   logic [1:0] row;
   logic [1:0] col;
   logic signed [31:0] pt;
   logic [48:0] mag;
   logic [63:0] sq_in;
   logic [64:0] s01, s012;
   logic [63:0] d2;
   logic signed [49:0] neg_z;
   logic [2:0] level;
   cam_result_type result_ff;

   assign row = elem_index[3:2];
   assign col = elem_index[1:0];

   always_comb begin
      case (col)
         2'd0: pt = point_x;
         2'd1: pt = point_y;
         default: pt = point_z;
      endcase
      // translation is scaled up so the common shift below leaves it exact
      if (col == 2'd3) prod_in = 64'($signed(rd_data)) <<< 16;
      else prod_in = $signed(rd_data) * pt;
   end

   // accumulate: floor of product by 2^16 is arithmetic shift
   // the first column of a row starts the row afresh
   always_comb begin
      for (int i = 0; i < 3; i++) acc_in[i] = acc_ff[i];
      if (prod_vld_ff) begin
         if (prod_first_ff)
            acc_in[prod_row_ff] = 49'(prod_ff >>> 16);
         else
            acc_in[prod_row_ff] = acc_ff[prod_row_ff] + 49'(prod_ff >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      prod_row_ff <= row;
      for (int i = 0; i < 3; i++) acc_ff[i] <= acc_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         prod_first_ff <= 1'b0;
         done1_ff <= 1'b0;
      end else begin
         prod_vld_ff <= elem_valid;
         prod_first_ff <= (col == 2'd0);
         done1_ff <= elem_valid && (elem_index == 4'd11);
      end
   end

   // squares of the three coordinates, one per cycle after accumulation
   always_comb begin
      mag = acc_ff[sq_row_ff][48] ? 49'(-acc_ff[sq_row_ff]) : acc_ff[sq_row_ff];
      if (mag[48:32] != '0) sq_in = '1;
      else sq_in = mag[31:0] * mag[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_row_ff <= '0;
         done2_ff <= 1'b0;
      end else begin
         if (done1_ff || sq_row_ff != 2'd0)
            sq_row_ff <= (sq_row_ff == 2'd2) ? 2'd0 : sq_row_ff + 2'd1;
         done2_ff <= (sq_row_ff == 2'd2);
      end
      if (done1_ff || sq_row_ff != 2'd0) sq_ff[sq_row_ff] <= sq_in;
   end

   always_comb begin
      s01 = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      s012 = {1'b0, (s01[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s01[63:0])} + {1'b0, sq_ff[2]};
      d2 = s012[64] ? '1 : s012[63:0];
      neg_z = -50'(acc_ff[2]);
      if (neg_z < 50'($signed(behind_limit))) level = LEVEL_ABSENT;
      else if (d2 < focus_sq) level = 3'd0;
      else if (d2 < high_sq) level = 3'd1;
      else if (d2 < medium_sq) level = 3'd2;
      else if (d2 < low_sq) level = 3'd3;
      else level = LEVEL_PERIPHERY;
   end

   always_ff @(posedge clock) begin
      if (reset) result_ff.valid <= 1'b0;
      else result_ff.valid <= done2_ff;
      result_ff.level <= level;
      result_ff.dist_sq <= d2;
   end

   assign result = result_ff;
endmodule

FILE: rtl/multi_camera_lod_classifier.sv
// top level: matrix memory, query sequencer and result register
// A query reads the twelve elements of each valid camera slot from one
// matrix memory, one element per cycle, then runs a drain before the
// answer is loaded into the output register. When slot 0 is not valid but
// a higher slot is, the query enters the drain state first and goes on
// from there to read that slot. Loads, clears and the unused request type
// are handled in the idle state. A finished answer waits in the output
// register while later requests are taken; a query that completes while
// that register is still full holds at the end of its drain until the
// waiting answer is taken. Matrix elements never loaded read as undefined.
module multi_camera_lod_classifier (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // camera_slot, element_index, element_value, point_x, point_y, point_z
   input logic [135:0] req_tdata,
   input logic [1:0] req_tuser,          // req_type
   output logic rsp_tvalid,
   input logic rsp_tready,
   // lod_level, min_distance_sq
   output logic [71:0] rsp_tdata,
   input logic csr_we,
   input logic [2:0] csr_index,
   input logic [63:0] csr_wdata
);
   import mclod_pkg::*;

   typedef enum logic [1:0] {IDLE, READ, DRAIN} state_type;

   state_type state_ff;
   logic [31:0] mem [StoreDepth];
   logic [31:0] rd_data_ff;
   logic [CameraSlots-1:0] valid_ff;
   logic [31:0] behind_ff;
   logic [63:0] focus_ff, high_ff, medium_ff, low_ff;
   logic [31:0] px_ff, py_ff, pz_ff;
   logic [SlotWidth-1:0] slot_ff;
   logic [3:0] elem_ff;
   logic rd_vld_ff;
   logic [3:0] rd_elem_ff;
   logic [3:0] drain_ff;
   logic [2:0] best_level_ff;
   logic [63:0] best_dist_ff;
   logic rsp_valid_ff;
   logic [2:0] rsp_level_ff;
   logic [63:0] rsp_dist_ff;
   logic accept;
   logic rsp_load;
   cam_result_type cam;
   logic [1:0] rq_type;
   logic [1:0] rq_slot;
   logic [3:0] rq_elem;
   logic [31:0] rq_value;
   logic has_next;
   logic [SlotWidth-1:0] next_slot;

   assign rq_type = req_tuser;
   assign rq_slot = req_tdata[1:0];
   assign rq_elem = req_tdata[5:2];
   assign rq_value = req_tdata[37:6];
   assign req_tready = (state_ff == IDLE);
   assign accept = req_tvalid && req_tready;

   // answer moves into the output register once that register is free
   assign rsp_load = (state_ff == DRAIN) && (drain_ff == 4'd10)
                     && (!rsp_valid_ff || rsp_tready);

   // find the next valid slot above the current one
   always_comb begin
      has_next = 1'b0;
      next_slot = '0;
      for (int i = CameraSlots - 1; i >= 0; i--) begin
         if (valid_ff[i] && SlotWidth'(i) > slot_ff) begin
            has_next = 1'b1;
            next_slot = SlotWidth'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rq_type == REQ_LOAD && rq_elem < 4'(ElemsPerCamera))
         mem[StoreAddrWidth'(rq_slot) * StoreAddrWidth'(ElemsPerCamera)
             + StoreAddrWidth'(rq_elem)] <= rq_value;
      rd_data_ff <= mem[StoreAddrWidth'(slot_ff) * StoreAddrWidth'(ElemsPerCamera)
                        + StoreAddrWidth'(elem_ff)];
      rd_elem_ff <= elem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         behind_ff <= 32'hFFF6_0000;
         focus_ff <= '0;
         high_ff <= '0;
         medium_ff <= '0;
         low_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BEHIND: behind_ff <= csr_wdata[31:0];
            CSR_FOCUS: focus_ff <= csr_wdata;
            CSR_HIGH: high_ff <= csr_wdata;
            CSR_MEDIUM: medium_ff <= csr_wdata;
            CSR_LOW: low_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= '0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff <= '0;
         elem_ff <= '0;
         drain_ff <= '0;
         best_level_ff <= LEVEL_ABSENT;
         best_dist_ff <= '1;
      end else begin
         rd_vld_ff <= (state_ff == READ);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_level_ff <= best_level_ff;
            rsp_dist_ff <= best_dist_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cam.valid) begin
            if (cam.level < best_level_ff) best_level_ff <= cam.level;
            if (cam.dist_sq < best_dist_ff) best_dist_ff <= cam.dist_sq;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  unique case (rq_type)
                     REQ_LOAD: if (rq_elem < 4'(ElemsPerCamera))
                        valid_ff[rq_slot] <= 1'b1;
                     REQ_CLEAR: valid_ff[rq_slot] <= 1'b0;
                     REQ_QUERY: begin
                        best_level_ff <= LEVEL_ABSENT;
                        best_dist_ff <= '1;
                        px_ff <= req_tdata[69:38];
                        py_ff <= req_tdata[101:70];
                        pz_ff <= req_tdata[133:102];
                        elem_ff <= '0;
                        drain_ff <= '0;
                        if (valid_ff[0]) begin
                           slot_ff <= '0;
                           state_ff <= READ;
                        end else begin
                           slot_ff <= '0;
                           state_ff <= DRAIN;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            READ: begin
               if (elem_ff == 4'd11) begin
                  elem_ff <= '0;
                  if (has_next) slot_ff <= next_slot;
                  else state_ff <= DRAIN;
               end else begin
                  elem_ff <= elem_ff + 4'd1;
               end
            end
            DRAIN: begin
               // first-slot check was skipped: pick up any valid higher slot
               if (drain_ff == 4'd0 && !valid_ff[0] && slot_ff == '0 && has_next
                   && elem_ff == 4'd0 && best_dist_ff == '1
                   && best_level_ff == LEVEL_ABSENT && !rd_vld_ff) begin
                  slot_ff <= next_slot;
                  state_ff <= READ;
               end else if (drain_ff == 4'd10) begin
                  if (rsp_load) state_ff <= IDLE;
               end else begin
                  drain_ff <= drain_ff + 4'd1;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   mclod_camera_unit u_cam (
      .clock(clock),
      .reset(reset),
      .elem_valid(rd_vld_ff),
      .elem_index(rd_elem_ff),
      .rd_data(rd_data_ff),
      .point_x(px_ff),
      .point_y(py_ff),
      .point_z(pz_ff),
      .behind_limit(behind_ff),
      .focus_sq(focus_ff),
      .high_sq(high_ff),
      .medium_sq(medium_ff),
      .low_sq(low_ff),
      .result(cam)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, rsp_dist_ff, rsp_level_ff};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == IDLE)) else $error("ready outside idle");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_level_ff <= LEVEL_ABSENT)) else $error("bad level");
   a_no_cam_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && $past(state_ff) == IDLE) |-> !rd_vld_ff)
      else $error("memory read while idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response changed while stalled");
endmodule
